// File: hw/rtl/btpc_pkg.sv
// Shared types and constants for the barometer compensation block.
// Used by every module of the block; depends on nothing.
`default_nettype none
package btpc_pkg;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 48;
  localparam logic [1:0] RegTempCalib  = 2'd0;
  localparam logic [1:0] RegPressCalA  = 2'd1;
  localparam logic [1:0] RegPressCalB  = 2'd2;
  localparam logic [1:0] RegPressCalC  = 2'd3;
  localparam logic OpTemp  = 1'b0;
  localparam logic OpPress = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [19:0] raw_sample;
  } in_beat_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] temp_centi;
    logic [31:0] press_q24_8;
    logic        zero_divisor;
  } out_beat_t;

  // Divider control between sequencer and divider.
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
  } div_rsp_t;
endpackage
`default_nettype wire

// File: hw/rtl/btpc_mul.sv
// Shared 32x32 multiplier, signed or unsigned per operand, used for three passes per 64-bit product.
// Depends on btpc_pkg.
`default_nettype none
module btpc_mul
  import btpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  input  wire logic        a_signed,
  input  wire logic        b_signed,
  output logic      [63:0] p
);
  logic signed [32:0] ax;
  logic signed [32:0] bx;
  logic signed [65:0] full;

  // Extend each operand by its own signedness, then register the product.
  assign ax   = {a_signed & a[31], a};
  assign bx   = {b_signed & b[31], b};
  assign full = ax * bx;

  always_ff @(posedge clk) begin
    p <= full[63:0];
  end
endmodule
`default_nettype wire

// File: hw/rtl/btpc_div.sv
// Restoring radix-2 divider, signed 64-bit, truncating toward zero.
// Depends on btpc_pkg.
`default_nettype none
module btpc_div
  import btpc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  logic [63:0] rem;
  logic [63:0] quo;
  logic [63:0] dvs;
  logic [6:0]  cnt;
  logic        busy;
  logic        neg;
  logic        done;
  logic [64:0] trial;

  assign trial = {rem, quo[63]} - {1'b0, dvs};

  // One quotient bit per cycle; sign fixed at the end.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
        rem  <= '0;
        quo  <= req.num[63] ? (64'd0 - req.num) : req.num;
        dvs  <= req.den[63] ? (64'd0 - req.den) : req.den;
        neg  <= req.num[63] ^ req.den[63];
      end else if (busy) begin
        if (trial[64]) begin
          rem <= {rem[62:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end else begin
          rem <= trial[63:0];
          quo <= {quo[62:0], 1'b1};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = {done, (neg ? (64'd0 - quo) : quo)};
endmodule
`default_nettype wire

// File: hw/rtl/baro_temp_pressure_compensation.sv
// Barometer compensation top level: sequencer, registers, multiplier, divider.
// Depends on btpc_pkg, btpc_mul and btpc_div.
//
// Usage: write the four calibration registers on the cfg port (cfg_we, cfg_idx,
// cfg_data) while idle. Send one beat on in_valid/in_ready carrying an opcode
// and a raw 20-bit count; one result beat leaves on out_valid/out_ready.
// A temperature beat stores the fine temperature used by later pressure beats.
// The sequencer drives the single shared 32x32 multiplier (three passes per
// 64-bit product) and the one-bit-per-cycle 64-bit divider. One beat is in
// work at a time; in_ready is low from acceptance until the result has been
// taken, so a stalled receiver simply holds the block. The next beat can be
// accepted in the cycle after the result beat is taken.
// Reset (rst, synchronous) clears calibration and fine temperature to zero.
`default_nettype none
module baro_temp_pressure_compensation
  import btpc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_idx,
  input  wire logic [CfgW-1:0]    cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire in_beat_t           in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output out_beat_t               out_data
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_ALU  = 6'b000100,
    S_DIV  = 6'b001000,
    S_DWT  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t      state;
  logic [47:0] tcal, pca, pcb, pcc;
  logic [31:0] fine;
  logic        op;
  logic [19:0] adc;
  logic [4:0]  step;
  logic [1:0]  part;
  logic [63:0] ma, mb, acc, r0, r1, r2, r3;
  logic        msg;
  logic [31:0] mul_a, mul_b;
  logic        mul_as, mul_bs;
  logic [63:0] mp;
  logic        div_start;
  div_req_t    dreq;
  div_rsp_t    drsp;

  // Calibration field extraction.
  logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, ft;
  assign t1 = {48'd0, tcal[15:0]};
  assign t2 = {{48{tcal[31]}}, tcal[31:16]};
  assign t3 = {{48{tcal[47]}}, tcal[47:32]};
  assign p1 = {48'd0, pca[15:0]};
  assign p2 = {{48{pca[31]}}, pca[31:16]};
  assign p3 = {{48{pca[47]}}, pca[47:32]};
  assign p4 = {{48{pcb[15]}}, pcb[15:0]};
  assign p5 = {{48{pcb[31]}}, pcb[31:16]};
  assign p6 = {{48{pcb[47]}}, pcb[47:32]};
  assign p7 = {{48{pcc[15]}}, pcc[15:0]};
  assign p8 = {{48{pcc[31]}}, pcc[31:16]};
  assign p9 = {{48{pcc[47]}}, pcc[47:32]};
  assign ft = {{32{fine[31]}}, fine};

  // 64x64 low product from three 32x32 passes: lo*lo, lo*hi, hi*lo.
  always_comb begin
    mul_as = 1'b0;
    mul_bs = 1'b0;
    unique case (part)
      2'd0: begin mul_a = ma[31:0];  mul_b = mb[31:0];  end
      2'd1: begin mul_a = ma[31:0];  mul_b = mb[63:32]; end
      2'd2: begin mul_a = ma[63:32]; mul_b = mb[31:0];  end
      default: begin
        mul_a = ma[31:0]; mul_b = mb[31:0];
        mul_as = msg; mul_bs = msg;
      end
    endcase
  end

  btpc_mul u_mul (.clk, .a(mul_a), .b(mul_b), .a_signed(mul_as),
                  .b_signed(mul_bs), .p(mp));
  btpc_div u_div (.clk, .rst, .req(dreq), .rsp(drsp));

  function automatic logic [63:0] asr(input logic [63:0] v, input logic [5:0] n);
    asr = 64'($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] n);
    asr32 = 32'($signed(v) >>> n);
  endfunction

  assign in_ready = (state == S_IDLE);

  // Sequencer: each step either multiplies ma*mb or does ALU work.
  // Temperature multiplications are 32-bit wrap (only acc[31:0] is used).
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tcal <= '0; pca <= '0; pcb <= '0; pcc <= '0;
      fine <= '0;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      step <= '0; part <= '0; msg <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_idx)
          RegTempCalib: tcal <= cfg_data;
          RegPressCalA: pca  <= cfg_data;
          RegPressCalB: pcb  <= cfg_data;
          default:      pcc  <= cfg_data;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op <= in_data.opcode;
            adc <= in_data.raw_sample;
            step <= '0;
            state <= S_ALU;
          end
        end
        S_MUL: begin
          // part counts 0..2 issue, each result arrives in the following cycle
          if (part == 2'd0) begin
            part <= 2'd1; msg <= 1'b0;
          end else if (part == 2'd1) begin
            acc <= mp; part <= 2'd2;
          end else if (part == 2'd2) begin
            acc[63:32] <= acc[63:32] + mp[31:0]; part <= 2'd3;
          end else begin
            acc[63:32] <= acc[63:32] + mp[31:0];
            part <= 2'd0;
            state <= S_ALU;
          end
        end
        S_ALU: begin
          step <= step + 5'd1;
          state <= S_MUL;
          part <= 2'd0;
          if (op == OpTemp) begin
            unique case (step)
              5'd0: begin
                ma <= {32'd0, {15'd0, adc[19:3]} - {t1[30:0], 1'b0}};
                mb <= t2;
              end
              5'd1: begin
                r0 <= {32'd0, asr32(acc[31:0], 5'd11)};
                ma <= {32'd0, {16'd0, adc[19:4]} - t1[31:0]};
                mb <= {32'd0, {16'd0, adc[19:4]} - t1[31:0]};
              end
              5'd2: begin
                ma <= {32'd0, asr32(acc[31:0], 5'd12)};
                mb <= t3;
              end
              5'd3: begin
                fine <= r0[31:0] + asr32(acc[31:0], 5'd14);
                ma <= {32'd0, r0[31:0] + asr32(acc[31:0], 5'd14)};
                mb <= 64'd5;
              end
              default: begin
                out_data.kind <= OpTemp;
                out_data.temp_centi <= asr32(acc[31:0] + 32'd128, 5'd8);
                out_data.press_q24_8 <= '0;
                out_data.zero_divisor <= 1'b0;
                out_valid <= 1'b1;
                state <= S_OUT;
              end
            endcase
          end else begin
            unique case (step)
              5'd0: begin
                r0 <= ft - 64'd128000;
                ma <= ft - 64'd128000; mb <= ft - 64'd128000;
              end
              5'd1: begin r1 <= acc; ma <= acc; mb <= p6; end
              5'd2: begin r2 <= acc; ma <= r0; mb <= p5; end
              5'd3: begin
                r2 <= r2 + (acc << 17) + (p4 << 35);
                ma <= r1; mb <= p3;
              end
              5'd4: begin r3 <= asr(acc, 6'd8); ma <= r0; mb <= p2; end
              5'd5: begin
                ma <= (64'd1 << 47) + r3 + (acc << 12); mb <= p1;
              end
              5'd6: begin
                r1 <= asr(acc, 6'd33);
                ma <= ((64'd1048576 - {44'd0, adc}) << 31) - r2;
                mb <= 64'd3125;
              end
              5'd7: begin
                if (r1 == 64'd0) begin
                  out_data.kind <= OpPress;
                  out_data.temp_centi <= '0;
                  out_data.press_q24_8 <= '0;
                  out_data.zero_divisor <= 1'b1;
                  out_valid <= 1'b1;
                  state <= S_OUT;
                end else begin
                  div_start <= 1'b1;
                  state <= S_DWT;
                end
              end
              5'd8: begin r0 <= acc; ma <= acc; mb <= asr(r3, 6'd0); end
              5'd9: begin ma <= acc; mb <= r3; end
              5'd10: begin r1 <= asr(acc, 6'd25); ma <= p8; mb <= r0; end
              default: begin
                out_data.kind <= OpPress;
                out_data.temp_centi <= '0;
                out_data.press_q24_8 <=
                  32'(asr(r0 + r1 + asr(acc, 6'd19), 6'd8) + (p7 << 4));
                out_data.zero_divisor <= 1'b0;
                out_valid <= 1'b1;
                state <= S_OUT;
              end
            endcase
          end
        end
        S_DWT: begin
          if (drsp.done) begin
            r0 <= drsp.quot;
            r3 <= asr(drsp.quot, 6'd13);
            ma <= p9; mb <= asr(drsp.quot, 6'd13);
            step <= 5'd9;
            part <= 2'd0;
            state <= S_MUL;
          end
        end
        S_DIV: state <= S_DWT;
        default: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign dreq = {div_start, acc, r1};
endmodule
`default_nettype wire

// File: hw/rtl/btpc_checker.sv
// Port-level checker for the compensation block, bound to the top level.
// Depends on btpc_pkg.
`default_nettype none
module btpc_checker
  import btpc_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_beat_t out_data
);
  // No new beat is taken while a result waits.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken with result pending");
  // A result follows an accepted beat, never directly.
  a_lat: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");
  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed while stalled");
  // Zero-divisor flag only with pressure results.
  a_zd: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.zero_divisor) |-> out_data.kind == OpPress)
    else $error("flag on temperature result");
endmodule

bind baro_temp_pressure_compensation btpc_checker u_chk (.*);
`default_nettype wire
